>>> design/bdlp_pkg.sv
package bdlp_pkg;

  // field widths and counts
  localparam int unsigned NumButtons = 4;
  localparam int unsigned NumHold    = 2;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned HoldW      = 16;
  localparam int unsigned StepW      = 7;
  localparam int unsigned DeltaW     = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 3;

  // command codes
  typedef enum logic [2:0] {
    CMD_FAN_ADJUST    = 3'd0,
    CMD_TOGGLE_WIFI   = 3'd1,
    CMD_RESET_WIFI    = 3'd2,
    CMD_TOGGLE_LIGHTS = 3'd3,
    CMD_TOGGLE_POWER  = 3'd4
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_IDLE_LEVELS      = 3'd0,
    REG_DEBOUNCE_TIME    = 3'd1,
    REG_WIFI_TOGGLE_HOLD = 3'd2,
    REG_WIFI_RESET_HOLD  = 3'd3,
    REG_FAN_STEP         = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [NumButtons-1:0] IdleLevelsRst     = 4'd0;
  localparam logic [HoldW-1:0]      DebounceTimeRst   = 16'd40;
  localparam logic [HoldW-1:0]      WifiToggleHoldRst = 16'd3000;
  localparam logic [HoldW-1:0]      WifiResetHoldRst  = 16'd8000;
  localparam logic [StepW-1:0]      FanStepRst        = 7'd5;

endpackage

>>> design/button_debounce_long_press.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_button_levels[3:0], in_now_time[31:0]
// out_    | output    | out_valid/out_stall| out_command_code[2:0], out_fan_delta[7:0] signed
// cfg_    | input     | cfg_we             | cfg_index[2:0], cfg_data[15:0]
//
// one poll per cycle while not stalled: a poll is captured in the input register,
// scanned combinationally against the button state, and any command lands in the
// result register, which drives out_
// a poll that gives no command just updates the button state
// out_stall holds the result register; the input register then holds its poll
// and in_stall rises, so at most one poll waits behind a stalled result
// rst_n (synchronous) restores register defaults and clears all button state
module button_debounce_long_press (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [bdlp_pkg::NumButtons-1:0]        in_button_levels,
  input  logic [bdlp_pkg::TimeW-1:0]             in_now_time,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [2:0]                             out_command_code,
  output logic signed [bdlp_pkg::DeltaW-1:0]     out_fan_delta,
  input  logic                                   cfg_we,
  input  logic [bdlp_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0]          cfg_data
);

  // configuration registers
  logic [bdlp_pkg::NumButtons-1:0] idle_levels_r;
  logic [bdlp_pkg::HoldW-1:0]      debounce_time_r;
  logic [bdlp_pkg::HoldW-1:0]      wifi_toggle_hold_r;
  logic [bdlp_pkg::HoldW-1:0]      wifi_reset_hold_r;
  logic [bdlp_pkg::StepW-1:0]      fan_step_r;

  // button state
  logic [bdlp_pkg::NumButtons-1:0] stable_r, stable_nxt;
  logic [bdlp_pkg::TimeW-1:0]      lc_time_r [bdlp_pkg::NumButtons];
  logic [bdlp_pkg::TimeW-1:0]      lc_time_nxt [bdlp_pkg::NumButtons];
  logic [bdlp_pkg::TimeW-1:0]      ps_time_r [bdlp_pkg::NumHold];
  logic [bdlp_pkg::TimeW-1:0]      ps_time_nxt [bdlp_pkg::NumHold];
  logic [bdlp_pkg::NumHold-1:0]    lp_done_r, lp_done_nxt;

  // input register
  logic                            in_valid_r;
  logic [bdlp_pkg::NumButtons-1:0] levels_r;
  logic [bdlp_pkg::TimeW-1:0]      now_r;

  // result register
  logic                            out_valid_r;
  bdlp_pkg::cmd_t                  code_r, code_nxt;
  logic [bdlp_pkg::DeltaW-1:0]     delta_r, delta_nxt;
  logic                            hit_nxt;

  // per-button terms
  logic [bdlp_pkg::NumButtons-1:0] raw_down;
  logic [bdlp_pkg::NumButtons-1:0] accept_change;
  logic [bdlp_pkg::NumHold-1:0]    start_hold;
  logic [bdlp_pkg::NumHold-1:0]    lp_fire;
  logic [bdlp_pkg::TimeW-1:0]      ps_start [bdlp_pkg::NumHold];
  logic [bdlp_pkg::TimeW-1:0]      hold_lim [bdlp_pkg::NumHold];

  logic                            proc_en;
  logic                            stop;
  logic [bdlp_pkg::DeltaW-1:0]     step_pos;

  // scan runs whenever the result register is free or being emptied
  assign proc_en  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !proc_en;

  assign out_valid        = out_valid_r;
  assign out_command_code = code_r;
  assign out_fan_delta    = delta_r;

  assign hold_lim[0] = {{(bdlp_pkg::TimeW-bdlp_pkg::HoldW){1'b0}}, wifi_toggle_hold_r};
  assign hold_lim[1] = {{(bdlp_pkg::TimeW-bdlp_pkg::HoldW){1'b0}}, wifi_reset_hold_r};
  assign step_pos    = {1'b0, fan_step_r};

  // debounce test for every button
  always_comb begin
    for (int i = 0; i < bdlp_pkg::NumButtons; i++) begin
      raw_down[i]      = levels_r[i] ^ idle_levels_r[i];
      accept_change[i] = (levels_r[i] != stable_r[i]) &&
                         ((now_r - lc_time_r[i]) >=
                          {{(bdlp_pkg::TimeW-bdlp_pkg::HoldW){1'b0}}, debounce_time_r});
    end
  end

  // hold timers of buttons 2 and 3
  always_comb begin
    for (int j = 0; j < bdlp_pkg::NumHold; j++) begin
      start_hold[j] = raw_down[j+2] && !(stable_r[j+2] ^ idle_levels_r[j+2]) &&
                      (ps_time_r[j] <= lc_time_r[j+2]);
      ps_start[j]   = start_hold[j] ? now_r : ps_time_r[j];
      lp_fire[j]    = raw_down[j+2] && !lp_done_r[j] &&
                      ((now_r - ps_start[j]) >= hold_lim[j]);
    end
  end

  // ordered scan, first command ends it
  always_comb begin
    stop        = 1'b0;
    hit_nxt     = 1'b0;
    code_nxt    = bdlp_pkg::CMD_FAN_ADJUST;
    delta_nxt   = '0;
    stable_nxt  = stable_r;
    lc_time_nxt = lc_time_r;
    ps_time_nxt = ps_time_r;
    lp_done_nxt = lp_done_r;
    // fan buttons
    for (int i = 0; i < 2; i++) begin
      if (!stop && accept_change[i]) begin
        lc_time_nxt[i] = now_r;
        stable_nxt[i]  = levels_r[i];
        if (raw_down[i]) begin
          stop      = 1'b1;
          hit_nxt   = 1'b1;
          code_nxt  = bdlp_pkg::CMD_FAN_ADJUST;
          delta_nxt = (i == 0) ? step_pos : 8'(8'd0 - step_pos);
        end
      end
    end
    // hold buttons
    for (int j = 0; j < bdlp_pkg::NumHold; j++) begin
      if (!stop) begin
        ps_time_nxt[j] = ps_start[j];
        if (lp_fire[j]) begin
          lp_done_nxt[j] = 1'b1;
          stop           = 1'b1;
          hit_nxt        = 1'b1;
          code_nxt       = (j == 0) ? bdlp_pkg::CMD_TOGGLE_WIFI : bdlp_pkg::CMD_RESET_WIFI;
        end else if (accept_change[j+2]) begin
          lc_time_nxt[j+2] = now_r;
          stable_nxt[j+2]  = levels_r[j+2];
          if (raw_down[j+2]) begin
            ps_time_nxt[j] = now_r;
            lp_done_nxt[j] = 1'b0;
          end else if (!lp_done_r[j]) begin
            stop     = 1'b1;
            hit_nxt  = 1'b1;
            code_nxt = (j == 0) ? bdlp_pkg::CMD_TOGGLE_LIGHTS :
                                  bdlp_pkg::CMD_TOGGLE_POWER;
          end
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_levels_r      <= bdlp_pkg::IdleLevelsRst;
      debounce_time_r    <= bdlp_pkg::DebounceTimeRst;
      wifi_toggle_hold_r <= bdlp_pkg::WifiToggleHoldRst;
      wifi_reset_hold_r  <= bdlp_pkg::WifiResetHoldRst;
      fan_step_r         <= bdlp_pkg::FanStepRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlp_pkg::REG_IDLE_LEVELS:      idle_levels_r <= cfg_data[bdlp_pkg::NumButtons-1:0];
        bdlp_pkg::REG_DEBOUNCE_TIME:    debounce_time_r <= cfg_data;
        bdlp_pkg::REG_WIFI_TOGGLE_HOLD: wifi_toggle_hold_r <= cfg_data;
        bdlp_pkg::REG_WIFI_RESET_HOLD:  wifi_reset_hold_r <= cfg_data;
        bdlp_pkg::REG_FAN_STEP:         fan_step_r <= cfg_data[bdlp_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      levels_r <= in_button_levels;
      now_r    <= in_now_time;
    end
  end

  // button state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r  <= '0;
      lp_done_r <= '0;
      for (int i = 0; i < bdlp_pkg::NumButtons; i++) begin
        lc_time_r[i] <= '0;
      end
      for (int j = 0; j < bdlp_pkg::NumHold; j++) begin
        ps_time_r[j] <= '0;
      end
    end else if (proc_en && in_valid_r) begin
      stable_r  <= stable_nxt;
      lp_done_r <= lp_done_nxt;
      lc_time_r <= lc_time_nxt;
      ps_time_r <= ps_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en) begin
      out_valid_r <= in_valid_r && hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && in_valid_r && hit_nxt) begin
      code_r  <= code_nxt;
      delta_r <= delta_nxt;
    end
  end

  // checks
  a_delta_only_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (code_r != bdlp_pkg::CMD_FAN_ADJUST) |-> delta_r == '0)
    else $error("fan delta set on a non-fan command");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with an empty input register");

  a_wifi_lp_emits: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lp_done_r[0]) |-> out_valid_r && (code_r == bdlp_pkg::CMD_TOGGLE_WIFI))
    else $error("button 2 long press without wifi toggle item");

  a_reset_lp_emits: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lp_done_r[1]) |-> out_valid_r && (code_r == bdlp_pkg::CMD_RESET_WIFI))
    else $error("button 3 long press without wifi reset item");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !proc_en |=> $stable(stable_r) && $stable(lp_done_r))
    else $error("button state moved while the scan was held");

endmodule

>>> sim/tb_button_debounce_long_press.sv
// tracks button state per poll and holds the commands still owed by the block
class panel_cmd_tracker;
  logic [3:0]  idle_lv;
  logic [15:0] debounce_ms;
  logic [15:0] wifi_toggle_ms;
  logic [15:0] wifi_reset_ms;
  logic [6:0]  step_pct;

  logic        stable_lv [4];
  logic [31:0] last_change [4];
  logic [31:0] hold_start [2];
  logic        hold_fired [2];

  bdlp_pkg::cmd_t      due_code [$];
  logic signed [7:0]   due_delta [$];
  int                  errors;

  function new();
    idle_lv        = bdlp_pkg::IdleLevelsRst;
    debounce_ms    = bdlp_pkg::DebounceTimeRst;
    wifi_toggle_ms = bdlp_pkg::WifiToggleHoldRst;
    wifi_reset_ms  = bdlp_pkg::WifiResetHoldRst;
    step_pct       = bdlp_pkg::FanStepRst;
    for (int b = 0; b < 4; b++) begin
      stable_lv[b]   = 1'b0;
      last_change[b] = '0;
    end
    for (int h = 0; h < 2; h++) begin
      hold_start[h] = '0;
      hold_fired[h] = 1'b0;
    end
    errors = 0;
  endfunction

  // register write, masked to each register's width, unused indexes dropped
  function void write_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      bdlp_pkg::REG_IDLE_LEVELS:      idle_lv        = data[3:0];
      bdlp_pkg::REG_DEBOUNCE_TIME:    debounce_ms    = data;
      bdlp_pkg::REG_WIFI_TOGGLE_HOLD: wifi_toggle_ms = data;
      bdlp_pkg::REG_WIFI_RESET_HOLD:  wifi_reset_ms  = data;
      bdlp_pkg::REG_FAN_STEP:         step_pct       = data[6:0];
      default: ;
    endcase
  endfunction

  function void owe(input bdlp_pkg::cmd_t code, input logic [7:0] delta);
    due_code.push_back(code);
    due_delta.push_back(delta);
  endfunction

  // one poll: scan buttons 0..3, the first command ends the scan
  function void note_poll(input logic [3:0] levels, input logic [31:0] now);
    logic        rd;
    logic        idl;
    logic        raw_dn;
    logic        deb_dn;
    int          h;
    logic [31:0] limit;
    logic [7:0]  step8;
    step8 = {1'b0, step_pct};
    h = 0;
    for (int b = 0; b < 4; b++) begin
      rd     = levels[b];
      idl    = idle_lv[b];
      raw_dn = rd != idl;
      deb_dn = stable_lv[b] != idl;
      // hold timing on the wifi buttons
      if (b >= 2) begin
        h     = b - 2;
        limit = (b == 2) ? {16'd0, wifi_toggle_ms} : {16'd0, wifi_reset_ms};
        if (raw_dn && !deb_dn && hold_start[h] <= last_change[b])
          hold_start[h] = now;
        if (raw_dn && !hold_fired[h] && (now - hold_start[h]) >= limit) begin
          hold_fired[h] = 1'b1;
          owe((b == 2) ? bdlp_pkg::CMD_TOGGLE_WIFI : bdlp_pkg::CMD_RESET_WIFI, 8'd0);
          return;
        end
      end
      // debounced level change
      if (rd != stable_lv[b] && (now - last_change[b]) >= {16'd0, debounce_ms}) begin
        last_change[b] = now;
        stable_lv[b]   = rd;
        if (rd != idl) begin
          if (b >= 2) begin
            hold_start[h] = now;
            hold_fired[h] = 1'b0;
          end else begin
            owe(bdlp_pkg::CMD_FAN_ADJUST, (b == 0) ? step8 : 8'd0 - step8);
            return;
          end
        end else if (b >= 2 && !hold_fired[h]) begin
          owe((b == 2) ? bdlp_pkg::CMD_TOGGLE_LIGHTS : bdlp_pkg::CMD_TOGGLE_POWER, 8'd0);
          return;
        end
      end
    end
  endfunction

  function int pending();
    return due_code.size();
  endfunction

  // compare one command from the block with the oldest owed one
  function void check_command(input logic [2:0] code, input logic signed [7:0] delta);
    bdlp_pkg::cmd_t    want_code;
    logic signed [7:0] want_delta;
    if (due_code.size() == 0) begin
      $error("command with none owed: command_code %0d fan_delta %0d", code, delta);
      errors++;
      return;
    end
    want_code  = due_code.pop_front();
    want_delta = due_delta.pop_front();
    if (code !== want_code) begin
      $error("command_code: expected %0d, actual %0d", want_code, code);
      errors++;
    end
    if (delta !== want_delta) begin
      $error("fan_delta: expected %0d, actual %0d", want_delta, delta);
      errors++;
    end
  endfunction
endclass

module tb_button_debounce_long_press;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         in_button_levels = '0;
  logic [31:0]        in_now_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_command_code;
  logic signed [7:0]  out_fan_delta;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  panel_cmd_tracker   tracker = new();
  logic [31:0]        poll_time;
  logic [3:0]         poll_levels;
  int                 calm_polls;
  int                 results_seen;

  button_debounce_long_press uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_levels (in_button_levels),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_code (out_command_code),
    .out_fan_delta    (out_fan_delta),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register write, one cycle of write enable
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [15:0] idle, input logic [15:0] deb,
                            input logic [15:0] wifi_tog, input logic [15:0] wifi_rst,
                            input logic [15:0] step);
    write_reg(bdlp_pkg::REG_IDLE_LEVELS, idle);
    write_reg(bdlp_pkg::REG_DEBOUNCE_TIME, deb);
    write_reg(bdlp_pkg::REG_WIFI_TOGGLE_HOLD, wifi_tog);
    write_reg(bdlp_pkg::REG_WIFI_RESET_HOLD, wifi_rst);
    write_reg(bdlp_pkg::REG_FAN_STEP, step);
  endtask

  // stop offering, let owed commands arrive, then allow for a silent poll in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offer one poll until taken, then maybe leave a gap
  task automatic send_poll(input logic [3:0] levels, input logic [31:0] now);
    int r;
    int gap;
    in_valid         <= 1'b1;
    in_button_levels <= levels;
    in_now_time      <= now;
    do @(posedge clk); while (!(in_valid && !in_stall));
    tracker.note_poll(levels, now);
    gap = 0;
    r = $urandom_range(0, 99);
    if (calm_polls > 0) calm_polls--;
    else if (r < 3) calm_polls = $urandom_range(20, 50);
    else if (r < 30) gap = $urandom_range(1, 3);
    else if (r < 34) gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly button presses and releases over advancing time, some noise
  task automatic run_polls(input int count);
    int          r;
    int          k;
    int unsigned step;
    if ($urandom_range(0, 1) == 0) poll_time = 32'hFFFF_0000 + $urandom_range(0, 65535);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      if (k < 6) step = $urandom_range(0, 60);
      else if (k < 8) step = $urandom_range(0, 400);
      else if (k == 8) step = $urandom_range(0, 10000);
      else step = $urandom_range(0, 70000);
      poll_time = poll_time + step;
      if (r < 75) begin
        if ($urandom_range(0, 2) == 0) poll_levels = poll_levels ^ 4'(1 << $urandom_range(0, 3));
      end else if (r < 90) begin
        poll_levels = 4'($urandom);
      end else begin
        poll_levels = 4'($urandom);
        poll_time   = $urandom;
      end
      send_poll(poll_levels, poll_time);
    end
  endtask

  // stimulus
  initial begin
    int wait_cycles;
    calm_polls  = 0;
    poll_time   = '0;
    poll_levels = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wifi buttons idle high while still reset to low: they read as held
    write_reg(bdlp_pkg::REG_IDLE_LEVELS, 16'h000C);
    send_poll(4'b1100, 32'd0);
    send_poll(4'b1100, 32'd50);
    send_poll(4'b1100, 32'd60);
    settle();
    write_reg(bdlp_pkg::REG_IDLE_LEVELS, 16'h0000);
    send_poll(4'b0000, 32'd200);
    send_poll(4'b0000, 32'd210);
    // fan up, bounce rejected, release, fan down
    send_poll(4'b0001, 32'd300);
    send_poll(4'b0000, 32'd310);
    send_poll(4'b0000, 32'd400);
    send_poll(4'b0010, 32'd500);
    send_poll(4'b0000, 32'd600);
    // short press on the wifi buttons, then long presses
    send_poll(4'b0100, 32'd700);
    send_poll(4'b0000, 32'd800);
    send_poll(4'b0100, 32'd900);
    send_poll(4'b0100, 32'd4000);
    send_poll(4'b0000, 32'd4100);
    send_poll(4'b1000, 32'd4200);
    send_poll(4'b1000, 32'd12300);
    send_poll(4'b0000, 32'd12400);
    send_poll(4'b1000, 32'd12500);
    send_poll(4'b0000, 32'd12600);
    // all pressed across the time wrap
    send_poll(4'b1111, 32'hFFFF_FFFF);
    send_poll(4'b1111, 32'h0000_0010);
    send_poll(4'b1111, 32'h0000_0100);
    send_poll(4'b0000, 32'h0000_2000);
    settle();

    // configuration phases, extremes among them
    set_config(16'h0000, 16'd40, 16'd200, 16'd500, 16'd5);
    run_polls(70);
    settle();
    set_config(16'h000F, 16'd0, 16'd0, 16'd0, 16'd100);
    run_polls(70);
    settle();
    set_config(16'hFFF6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = bdlp_pkg::REG_FAN_STEP + 1; i < 8; i++) write_reg(3'(i), 16'($urandom));
    run_polls(70);
    settle();
    set_config(16'($urandom), 16'($urandom_range(0, 200)), 16'($urandom_range(0, 3000)),
               16'($urandom_range(0, 3000)), 16'd0);
    run_polls(70);
    settle();
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    for (int i = bdlp_pkg::REG_FAN_STEP + 1; i < 8; i++) write_reg(3'(i), 16'($urandom));
    run_polls(70);
    settle();
    set_config(16'h0000, 16'd40, 16'd3000, 16'd8000, 16'd5);
    run_polls(70);
    settle();
    set_config(16'($urandom), 16'($urandom_range(0, 100)), 16'($urandom_range(0, 1000)),
               16'($urandom_range(0, 1000)), 16'($urandom_range(0, 127)));
    run_polls(70);

    // drain and give any stray command time to show up
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (tracker.pending() != 0 && wait_cycles < 50000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0)
      $error("commands never delivered: %0d", tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: check each command taken, stall at random
  initial begin
    int r;
    int stall_left;
    int calm_left;
    int hold_left;
    bit held_once;
    stall_left   = 0;
    calm_left    = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_command(out_command_code, out_fan_delta);
        results_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (!held_once && results_seen >= 25) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 2) calm_left = $urandom_range(20, 60);
          else if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 23) stall_left = $urandom_range(10, 40);
        end
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
